// ===== hdl/twhbl_pkg.sv =====
// Package: shared types and codes for the two-wire handshake byte link.
`timescale 1ns / 1ps
`default_nettype none

package twhbl_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned IdxW        = $clog2(BitsPerByte);
  localparam int unsigned TimeoutW    = 24;
  localparam int unsigned ByteW       = 8;

  localparam logic [TimeoutW-1:0] EdgeTimeoutReset = 24'd65535;

  // Command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SEND = 2'd1;
  localparam logic [1:0] CMD_RECV = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // Register word index
  localparam logic REG_EDGE_TIMEOUT = 1'b0;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_TX_FREE1 = 3'd1,
    PH_TX_ACK   = 3'd2,
    PH_TX_FREE2 = 3'd3,
    PH_RX_START = 3'd4,
    PH_RX_REL   = 3'd5,
    PH_RX_FREE  = 3'd6
  } phase_e;

  typedef struct packed {
    logic [1:0]          command;
    logic [ByteW-1:0]    send_value;
    logic [TimeoutW-1:0] first_bit_timeout;
    logic                tip_is_low;
    logic                ring_is_low;
  } in_item_t;

  typedef struct packed {
    logic             pull_tip;
    logic             pull_ring;
    logic             busy_res;
    logic             done_res;
    logic [1:0]       status;
    logic [ByteW-1:0] received_value;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/two_wire_handshake_byte_link_core.sv =====
// Top level of the two-wire handshake byte link engine.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_item_i) carries one item
//   per timebase tick: the sampled tip and ring levels plus, when the engine
//   is idle, a send or receive command. Each accepted item yields exactly one
//   result item on the output channel (out_valid_o / out_ready_i /
//   out_item_o): the line drive levels, busy, a done pulse with status, and
//   the received byte on a successful receive.
//   The engine steps on the accept edge and its result is registered in the
//   result buffer, from which it is offered. Throughput: one item per cycle
//   while the buffer has room, set by the single engine step before the buffer.
//   A receiver stall is absorbed by a two-entry result buffer; in_ready_o
//   drops only when both entries are full, and results are never dropped.
//   The APB port holds edge_timeout at byte address 0; writes take effect on
//   the next accepted item and should be done while the link is idle.
//   Reset: engine idle, both lines released, result buffer empty,
//   edge_timeout back to 65535. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module two_wire_handshake_byte_link_core import twhbl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // item input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_item_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_item_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [TimeoutW-1:0] edge_timeout;
  logic                step;
  logic                buf_space;
  out_item_t           step_res;

  // Accept whenever the result buffer has room for this item's result
  assign in_ready_o = buf_space;
  assign step       = in_valid_i && buf_space;

  twhbl_apb_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .edge_timeout_o (edge_timeout)
  );

  twhbl_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .item_i         (in_item_i),
    .edge_timeout_i (edge_timeout),
    .res_o          (step_res)
  );

  twhbl_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .item_i  (step_res),
    .space_o (buf_space),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== hdl/twhbl_apb_regs.sv =====
// APB register block holding the edge timeout.
`timescale 1ns / 1ps
`default_nettype none

module twhbl_apb_regs import twhbl_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  output logic      [TimeoutW-1:0] edge_timeout_o
);

  logic [TimeoutW-1:0] edge_timeout_q;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_EDGE_TIMEOUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_timeout_q <= EdgeTimeoutReset;
    end else if (wr_en) begin
      edge_timeout_q <= pwdata[TimeoutW-1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_EDGE_TIMEOUT) begin
      prdata = {{(32-TimeoutW){1'b0}}, edge_timeout_q};
    end
  end

  // paddr[1:0] are byte lanes within the word and are not decoded
  assign edge_timeout_o = edge_timeout_q;

endmodule

`default_nettype wire

// ===== hdl/twhbl_engine.sv =====
// Link engine: state machine that advances one step per accepted item.
`timescale 1ns / 1ps
`default_nettype none

module twhbl_engine import twhbl_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire in_item_t            item_i,
  input  wire logic [TimeoutW-1:0] edge_timeout_i,
  output out_item_t                res_o
);

  phase_e              phase_q, phase_d;
  logic                is_rx_q, is_rx_d;
  logic [ByteW-1:0]    shift_q, shift_d;
  logic [IdxW:0]       idx_q, idx_d;
  logic                cur_q, cur_d;
  logic [TimeoutW-1:0] wait_q, wait_d;
  logic [TimeoutW-1:0] start_lim_q, start_lim_d;
  logic                tip_q, tip_d;
  logic                ring_q, ring_d;

  logic [TimeoutW-1:0] wait_inc;
  logic [TimeoutW-1:0] rx_limit;
  logic                lines_free;
  logic                done;
  logic [1:0]          status;
  logic [ByteW-1:0]    rx_value;

  assign wait_inc   = wait_q + TimeoutW'(1);
  assign rx_limit   = (idx_q == '0) ? start_lim_q : edge_timeout_i;
  assign lines_free = !item_i.tip_is_low && !item_i.ring_is_low;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      is_rx_q     <= 1'b0;
      shift_q     <= '0;
      idx_q       <= '0;
      cur_q       <= 1'b0;
      wait_q      <= '0;
      start_lim_q <= '0;
      tip_q       <= 1'b0;
      ring_q      <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      is_rx_q     <= is_rx_d;
      shift_q     <= shift_d;
      idx_q       <= idx_d;
      cur_q       <= cur_d;
      wait_q      <= wait_d;
      start_lim_q <= start_lim_d;
      tip_q       <= tip_d;
      ring_q      <= ring_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    is_rx_d     = is_rx_q;
    shift_d     = shift_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    wait_d      = wait_q;
    start_lim_d = start_lim_q;
    tip_d       = tip_q;
    ring_d      = ring_q;
    done        = 1'b0;
    status      = ST_OK;
    rx_value    = '0;

    unique case (phase_q)
      PH_IDLE: begin
        if (item_i.command == CMD_SEND || item_i.command == CMD_RECV) begin
          is_rx_d     = (item_i.command == CMD_RECV);
          shift_d     = is_rx_d ? '0 : item_i.send_value;
          start_lim_d = item_i.first_bit_timeout;
          idx_d       = '0;
          cur_d       = 1'b0;
          wait_d      = '0;
          phase_d     = is_rx_d ? PH_RX_START : PH_TX_FREE1;
        end
      end
      PH_TX_FREE1: begin
        if (lines_free) begin
          cur_d = shift_q[idx_q[IdxW-1:0]];
          if (!cur_d) begin
            tip_d = 1'b1;
          end else begin
            ring_d = 1'b1;
          end
          wait_d  = '0;
          phase_d = PH_TX_ACK;
        end else begin
          wait_d = wait_inc;
          if (wait_inc >= edge_timeout_i) begin
            tip_d = 1'b0; ring_d = 1'b0; phase_d = PH_IDLE; wait_d = '0;
            done = 1'b1; status = ST_TIMEOUT;
          end
        end
      end
      PH_TX_ACK: begin
        if (!cur_q ? item_i.ring_is_low : item_i.tip_is_low) begin
          if (!cur_q) begin
            tip_d = 1'b0;
          end else begin
            ring_d = 1'b0;
          end
          wait_d  = '0;
          phase_d = PH_TX_FREE2;
        end else begin
          wait_d = wait_inc;
          if (wait_inc >= edge_timeout_i) begin
            tip_d = 1'b0; ring_d = 1'b0; phase_d = PH_IDLE; wait_d = '0;
            done = 1'b1; status = ST_TIMEOUT;
          end
        end
      end
      PH_TX_FREE2, PH_RX_FREE: begin
        if (lines_free) begin
          if (phase_q == PH_RX_FREE) begin
            shift_d = shift_q | (ByteW'(cur_q) << idx_q[IdxW-1:0]);
          end
          idx_d  = idx_q + (IdxW+1)'(1);
          wait_d = '0;
          if (idx_d >= (IdxW+1)'(BitsPerByte)) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
            status  = ST_OK;
            if (is_rx_q) begin
              rx_value = shift_d;
            end
          end else if (is_rx_q) begin
            phase_d = PH_RX_START;
          end else begin
            phase_d = PH_TX_FREE1;
          end
        end else begin
          wait_d = wait_inc;
          if (wait_inc >= edge_timeout_i) begin
            tip_d = 1'b0; ring_d = 1'b0; phase_d = PH_IDLE; wait_d = '0;
            done = 1'b1; status = ST_TIMEOUT;
          end
        end
      end
      PH_RX_START: begin
        if (lines_free) begin
          wait_d = wait_inc;
          if (wait_inc >= rx_limit) begin
            tip_d = 1'b0; ring_d = 1'b0; phase_d = PH_IDLE; wait_d = '0;
            done = 1'b1; status = ST_TIMEOUT;
          end
        end else if (item_i.tip_is_low && item_i.ring_is_low) begin
          // both lines low at bit start: not a legal edge
          tip_d = 1'b0; ring_d = 1'b0; phase_d = PH_IDLE; wait_d = '0;
          done = 1'b1; status = ST_INVALID;
        end else begin
          cur_d = !item_i.tip_is_low;
          if (!cur_d) begin
            ring_d = 1'b1;
          end else begin
            tip_d = 1'b1;
          end
          wait_d  = '0;
          phase_d = PH_RX_REL;
        end
      end
      PH_RX_REL: begin
        if (!cur_q ? !item_i.tip_is_low : !item_i.ring_is_low) begin
          if (!cur_q) begin
            ring_d = 1'b0;
          end else begin
            tip_d = 1'b0;
          end
          wait_d  = '0;
          phase_d = PH_RX_FREE;
        end else begin
          wait_d = wait_inc;
          if (wait_inc >= edge_timeout_i) begin
            tip_d = 1'b0; ring_d = 1'b0; phase_d = PH_IDLE; wait_d = '0;
            done = 1'b1; status = ST_TIMEOUT;
          end
        end
      end
      default: begin
        tip_d   = 1'b0;
        ring_d  = 1'b0;
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.pull_tip       = tip_d;
    res_o.pull_ring      = ring_d;
    res_o.busy_res       = (phase_d != PH_IDLE);
    res_o.done_res       = done;
    res_o.status         = status;
    res_o.received_value = rx_value;
  end

`ifndef SYNTHESIS
  a_one_line_driven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tip_q && ring_q))
    else $error("engine drives both lines");

  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (!tip_q && !ring_q))
    else $error("line driven while idle");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && done) |=> (phase_q == PH_IDLE && wait_q == '0))
    else $error("transfer ended but engine not idle");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (idx_q < (IdxW+1)'(BitsPerByte)))
    else $error("bit index past end of byte while busy");
`endif

endmodule

`default_nettype wire

// ===== hdl/twhbl_out_buf.sv =====
// Two-entry result buffer that decouples the engine from a stalled receiver.
`timescale 1ns / 1ps
`default_nettype none

module twhbl_out_buf import twhbl_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire out_item_t item_i,
  output logic           space_o,
  output logic           valid_o,
  input  wire logic      ready_i,
  output out_item_t      item_o
);

  out_item_t   head_q, tail_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        pop;

  assign space_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign item_o  = head_q;

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (cnt_q == 2'd2) begin
      if (pop) begin
        head_q <= tail_q;
      end
    end else if (cnt_q == 2'd1) begin
      if (push_i && pop) begin
        head_q <= item_i;
      end else if (push_i) begin
        tail_q <= item_i;
      end
    end else if (push_i) begin
      head_q <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !push_i)
    else $error("push into full result buffer");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> (valid_o && $stable(head_q)))
    else $error("head item changed while stalled");
`endif

endmodule

`default_nettype wire
